// ===== rtl/core/min_distance_point_thinning_defines.svh =====
// assertion macros shared by the point thinning checker
// no dependencies; expects i_clk and i_rst_n in the scope of use
`ifndef MIN_DISTANCE_POINT_THINNING_DEFINES_SVH
`define MIN_DISTANCE_POINT_THINNING_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define MDPT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mdpt same-cycle check failed");

// next-cycle implication, disabled while in reset
`define MDPT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mdpt next-cycle check failed");

`endif

// ===== rtl/core/mdpt_pkg.sv =====
// shared types and constants for the minimum distance point thinning block
// no dependencies
package mdpt_pkg;

    localparam int COORD_W    = 16;
    localparam int CMD_W      = 2;
    localparam int CNT_OUT_W  = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int DIST_W     = 16;
    localparam int SQ_W       = 2 * COORD_W;

    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TEST  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DETECT_EN = 2'd1;

    localparam logic [DIST_W-1:0] MIN_DIST_RESET = 16'd480;

    // controller to datapath
    typedef struct packed {
        logic load_item;
        logic scan_start;
        logic rd_issue;
        logic commit;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic need_scan;
        logic last_addr;
        logic pipe_busy;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== rtl/core/mdpt_ctrl.sv =====
// sequencer for the point thinning block: accept, scan, drain, commit
// depends on mdpt_pkg for the command and status structs
module mdpt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  mdpt_pkg::t_dp_stat i_stat,
    output mdpt_pkg::t_dp_cmd  o_cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (i_stat.need_scan) begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = ST_SCAN;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_SCAN: begin
                o_cmd.rd_issue = 1'b1;
                if (i_stat.last_addr) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // wait for the last compare to land in the near flag
                if (!i_stat.pipe_busy) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/mdpt_datapath.sv =====
// point store, distance compare pipeline, count and result register
// depends on mdpt_pkg for constants and the command and status structs
module mdpt_datapath #(
    parameter int STORE_DEPTH = 256
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mdpt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mdpt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic [mdpt_pkg::CMD_W-1:0]      i_cmd,
    input  logic [mdpt_pkg::COORD_W-1:0]    i_point_x,
    input  logic [mdpt_pkg::COORD_W-1:0]    i_point_y,
    input  mdpt_pkg::t_dp_cmd               i_ctl,
    output mdpt_pkg::t_dp_stat              o_stat,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_accepted,
    output logic [mdpt_pkg::COORD_W-1:0]    o_out_x,
    output logic [mdpt_pkg::COORD_W-1:0]    o_out_y,
    output logic                            o_overflow,
    output logic [mdpt_pkg::CNT_OUT_W-1:0]  o_stored_count
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int CW = $clog2(STORE_DEPTH + 1);
    localparam int CW_ = mdpt_pkg::COORD_W;
    localparam int SW  = mdpt_pkg::SQ_W;

    // config
    logic [mdpt_pkg::DIST_W-1:0] r_min_dist;
    logic                        r_detect_en;
    logic [SW-1:0]               r_limit;

    // item
    logic [mdpt_pkg::CMD_W-1:0] r_cmd;
    logic [CW_-1:0]             r_x;
    logic [CW_-1:0]             r_y;

    // store
    logic [2*CW_-1:0] r_mem [STORE_DEPTH];
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic [AW-1:0]    r_rd_addr;

    // compare pipeline
    logic             r_v1;
    logic             r_v2;
    logic             r_v3;
    logic [2*CW_-1:0] r_rdata;
    logic [CW_-1:0]   r_dx;
    logic [CW_-1:0]   r_dy;
    logic [SW-1:0]    r_sqx;
    logic [SW-1:0]    r_sqy;
    logic [SW:0]      dist_sum;
    logic             r_near;

    logic             store_full;
    logic             mem_we;
    logic             n_acc;
    logic             n_ovf;
    logic             r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_dist  <= mdpt_pkg::MIN_DIST_RESET;
            r_detect_en <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mdpt_pkg::CFG_MIN_DIST:  r_min_dist  <= i_cfg_data;
                mdpt_pkg::CFG_DETECT_EN: r_detect_en <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_limit <= r_min_dist * r_min_dist;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_item) begin
            r_cmd <= i_cmd;
            r_x   <= i_point_x;
            r_y   <= i_point_y;
        end
    end

    // one stored point read per cycle
    always_ff @(posedge i_clk) begin
        if (i_ctl.scan_start) begin
            r_rd_addr <= '0;
        end else if (i_ctl.rd_issue) begin
            r_rd_addr <= r_rd_addr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_issue) begin
            r_rdata <= r_mem[r_rd_addr];
        end
        if (mem_we) begin
            r_mem[r_count[AW-1:0]] <= {r_x, r_y};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_ctl.rd_issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_dx <= (r_x >= r_rdata[2*CW_-1:CW_]) ? (r_x - r_rdata[2*CW_-1:CW_])
                                                  : (r_rdata[2*CW_-1:CW_] - r_x);
            r_dy <= (r_y >= r_rdata[CW_-1:0]) ? (r_y - r_rdata[CW_-1:0])
                                              : (r_rdata[CW_-1:0] - r_y);
        end
        if (r_v2) begin
            r_sqx <= r_dx * r_dx;
            r_sqy <= r_dy * r_dy;
        end
    end

    assign dist_sum = {1'b0, r_sqx} + {1'b0, r_sqy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near <= 1'b0;
        end else if (i_ctl.load_item) begin
            r_near <= 1'b0;
        end else if (r_v3 && (dist_sum < {1'b0, r_limit})) begin
            r_near <= 1'b1;
        end
    end

    assign store_full = (r_count == CW'(STORE_DEPTH));

    always_comb begin
        n_count = r_count;
        mem_we  = 1'b0;
        n_acc   = 1'b0;
        n_ovf   = 1'b0;
        case (r_cmd)
            mdpt_pkg::CMD_CLEAR: begin
                n_count = '0;
            end
            mdpt_pkg::CMD_LOAD: begin
                if (store_full) begin
                    n_ovf = 1'b1;
                end else begin
                    mem_we  = i_ctl.commit;
                    n_count = r_count + CW'(1);
                end
            end
            mdpt_pkg::CMD_TEST: begin
                if (r_detect_en && !r_near) begin
                    if (store_full) begin
                        n_ovf = 1'b1;
                    end else begin
                        mem_we  = i_ctl.commit;
                        n_acc   = 1'b1;
                        n_count = r_count + CW'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctl.commit) begin
            r_count <= n_count;
        end
    end

    // result register, loaded when empty or drained in the same cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.commit) begin
            o_accepted     <= n_acc;
            o_overflow     <= n_ovf;
            o_out_x        <= r_x;
            o_out_y        <= r_y;
            o_stored_count <= mdpt_pkg::CNT_OUT_W'(n_count);
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_stat.need_scan = (r_cmd == mdpt_pkg::CMD_TEST) && r_detect_en && (r_count != '0);
    assign o_stat.last_addr = ((CW'(r_rd_addr) + CW'(1)) == r_count);
    assign o_stat.pipe_busy = r_v1 | r_v2 | r_v3;
    assign o_stat.out_free  = !r_out_valid || !i_out_stall;

endmodule

// ===== rtl/core/min_distance_point_thinning.sv =====
// top level of the minimum distance point thinning block
// depends on mdpt_pkg, mdpt_ctrl and mdpt_datapath
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+------------------------------------
//  in       | in        | i_in_valid / o_in_stall   | i_cmd, i_point_x, i_point_y
//  out      | out       | o_out_valid / i_out_stall | o_accepted, o_out_x, o_out_y,
//           |           |                           | o_overflow, o_stored_count
//  cfg      | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// clear, load, disabled test and unused commands skip the scan: accept, check, commit
// a test against N stored points scans them with one store read per cycle
// through a four stage read, diff, square, compare pipeline
// one item is in work at a time; the next beat is taken while a result waits on the output
// reset empties the store by zeroing the count; store contents need no clearing
// a stalled output holds the finished item in the sequencer until the register frees
module min_distance_point_thinning #(
    parameter int STORE_DEPTH = 256
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [mdpt_pkg::CMD_W-1:0]      i_cmd,
    input  logic [mdpt_pkg::COORD_W-1:0]    i_point_x,
    input  logic [mdpt_pkg::COORD_W-1:0]    i_point_y,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_accepted,
    output logic [mdpt_pkg::COORD_W-1:0]    o_out_x,
    output logic [mdpt_pkg::COORD_W-1:0]    o_out_y,
    output logic                            o_overflow,
    output logic [mdpt_pkg::CNT_OUT_W-1:0]  o_stored_count,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [mdpt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mdpt_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    mdpt_pkg::t_dp_cmd  dp_cmd;
    mdpt_pkg::t_dp_stat dp_stat;

    assign o_cfg_ready = 1'b1;

    mdpt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    mdpt_datapath #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_valid && o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_cmd          (i_cmd),
        .i_point_x      (i_point_x),
        .i_point_y      (i_point_y),
        .i_ctl          (dp_cmd),
        .o_stat         (dp_stat),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_accepted     (o_accepted),
        .o_out_x        (o_out_x),
        .o_out_y        (o_out_y),
        .o_overflow     (o_overflow),
        .o_stored_count (o_stored_count)
    );

endmodule

// ===== rtl/core/mdpt_checker.sv =====
// port-level checks for the point thinning block, bound to the top level
// depends on min_distance_point_thinning_defines.svh and mdpt_pkg
`include "min_distance_point_thinning_defines.svh"

module mdpt_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_stall,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input logic                           o_accepted,
    input logic                           o_overflow,
    input logic [mdpt_pkg::COORD_W-1:0]   o_out_x,
    input logic [mdpt_pkg::COORD_W-1:0]   o_out_y,
    input logic [mdpt_pkg::CNT_OUT_W-1:0] o_stored_count
);

    // a result beat never claims both a store and an overflow
    `MDPT_ASSERT_NOW(a_acc_ovf_excl, o_out_valid, !(o_accepted && o_overflow))

    // one item at a time: after an accepted beat the input stalls
    `MDPT_ASSERT_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall)

    // stalled result beat holds
    `MDPT_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_x) && $stable(o_out_y) && $stable(o_accepted) && $stable(o_overflow) && $stable(o_stored_count))

endmodule

bind min_distance_point_thinning mdpt_checker u_mdpt_checker (.*);
